[rtl/sme_pkg.sv]
package sme_pkg;

  localparam int unsigned OPCODE_W    = 4;
  localparam int unsigned WORD_W      = 64;
  localparam int unsigned STATUS_W    = 3;
  localparam int unsigned PLEN_W      = 11;
  localparam int unsigned DEPTH_OUT_W = 11;

  typedef logic [WORD_W-1:0] word_t;

  // instruction codes; codes above emit are illegal
  typedef enum logic [OPCODE_W-1:0] {
    OP_NOP    = 4'd0,
    OP_PUSH   = 4'd1,
    OP_DUP    = 4'd2,
    OP_ADD    = 4'd3,
    OP_SUB    = 4'd4,
    OP_MUL    = 4'd5,
    OP_DIV    = 4'd6,
    OP_JMP    = 4'd7,
    OP_JMP_IF = 4'd8,
    OP_EQ     = 4'd9,
    OP_HALT   = 4'd10,
    OP_EMIT   = 4'd11
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK              = 3'd0,
    ST_OVERFLOW        = 3'd1,
    ST_UNDERFLOW       = 3'd2,
    ST_ILLEGAL_OP      = 3'd3,
    ST_DIV_ZERO        = 3'd4,
    ST_ILLEGAL_ACCESS  = 3'd5,
    ST_ILLEGAL_OPERAND = 3'd6,
    ST_OK_NOP          = 3'd7
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD,
    S_RD2,
    S_MUL,
    S_DIV,
    S_WB
  } state_e;

endpackage

[rtl/sme_in_if.sv]
interface sme_in_if;
  import sme_pkg::*;

  logic                valid;
  logic                ready;
  logic [OPCODE_W-1:0] opcode;
  word_t               operand;

  modport source (output valid, output opcode, output operand, input ready);
  modport sink   (input valid, input opcode, input operand, output ready);
endinterface

[rtl/sme_out_if.sv]
interface sme_out_if;
  import sme_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [STATUS_W-1:0]    status;
  word_t                  next_pointer;
  logic                   halted;
  logic                   emit_valid;
  word_t                  emit_value;
  logic [DEPTH_OUT_W-1:0] stack_depth;

  modport source (output valid, output status, output next_pointer, output halted,
                  output emit_valid, output emit_value, output stack_depth,
                  input ready);
  modport sink   (input valid, input status, input next_pointer, input halted,
                  input emit_valid, input emit_value, input stack_depth,
                  output ready);
endinterface

[rtl/sme_cfg_if.sv]
interface sme_cfg_if;
  import sme_pkg::*;

  logic              valid;
  logic              ready;
  logic [PLEN_W-1:0] program_length;

  modport source (output valid, output program_length, input ready);
  modport sink   (input valid, input program_length, output ready);
endinterface

[rtl/sme_mul.sv]
module sme_mul (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  sme_pkg::word_t a_i,
  input  sme_pkg::word_t b_i,
  output logic          done_o,
  output sme_pkg::word_t result_o
);
  import sme_pkg::*;

  localparam int unsigned HW = WORD_W / 2;

  logic           busy_q;
  logic [1:0]     cnt_q;
  logic           done_q;
  word_t          a_q, b_q, prod_q, acc_q;
  logic [HW-1:0]  mul_a, mul_b;
  word_t          prod;

  // one half-width multiplier, low half of the cross terms only
  always_comb begin
    mul_a = (cnt_q == 2'd2) ? a_q[WORD_W-1:HW] : a_q[HW-1:0];
    mul_b = (cnt_q == 2'd1) ? b_q[WORD_W-1:HW] : b_q[HW-1:0];
    prod  = WORD_W'(mul_a) * WORD_W'(mul_b);
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= busy_q && (cnt_q == 2'd3);
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 2'd1;
        if (cnt_q == 2'd3) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  // partial products, registered before accumulation
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q   <= a_i;
      b_q   <= b_i;
      acc_q <= '0;
    end else if (busy_q) begin
      prod_q <= prod;
      case (cnt_q)
        2'd1:    acc_q <= prod_q;
        2'd2:    acc_q <= acc_q + {prod_q[HW-1:0], {HW{1'b0}}};
        2'd3:    acc_q <= acc_q + {prod_q[HW-1:0], {HW{1'b0}}};
        default: acc_q <= acc_q;
      endcase
    end
  end

  assign done_o   = done_q;
  assign result_o = acc_q;

endmodule

[rtl/sme_div.sv]
module sme_div (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  sme_pkg::word_t a_i,
  input  sme_pkg::word_t b_i,
  output logic          done_o,
  output sme_pkg::word_t result_o
);
  import sme_pkg::*;

  localparam int unsigned CW = $clog2(WORD_W);

  logic          busy_q;
  logic [CW-1:0] cnt_q;
  logic          done_q;
  logic          neg_q;
  word_t         mb_q, rem_q, quo_q;
  logic [WORD_W:0] shifted, diff;

  // one restoring step per cycle
  always_comb begin
    shifted = {rem_q, quo_q[WORD_W-1]};
    diff    = shifted - {1'b0, mb_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= busy_q && (cnt_q == CW'(WORD_W - 1));
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CW'(1);
        if (cnt_q == CW'(WORD_W - 1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  // magnitudes on start, quotient sign applied at the end
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q <= a_i[WORD_W-1] ^ b_i[WORD_W-1];
      quo_q <= a_i[WORD_W-1] ? (-a_i) : a_i;
      mb_q  <= b_i[WORD_W-1] ? (-b_i) : b_i;
      rem_q <= '0;
    end else if (busy_q) begin
      if (!diff[WORD_W]) begin
        rem_q <= diff[WORD_W-1:0];
        quo_q <= {quo_q[WORD_W-2:0], 1'b1};
      end else begin
        rem_q <= shifted[WORD_W-1:0];
        quo_q <= {quo_q[WORD_W-2:0], 1'b0};
      end
    end
  end

  assign done_o   = done_q;
  assign result_o = neg_q ? (-quo_q) : quo_q;

endmodule

[rtl/stack_machine_execute_unit_top.sv]
// Stack-machine execute unit: runs one instruction per input transaction.
// Channels: inst_i carries opcode and operand fetched at next_pointer of the
// previous result; res_o returns one result per instruction (status, new
// pointer, halt flag, emitted value, stack depth); cfg_i writes program_length;
// the user must write it only while the unit is idle; the block does not enforce this.
// Sequence per instruction: nop, push, jmp, halt and every error found on accept
// go straight to write-back; dup, jmp_if and emit first do one stack read, and
// so does a divide by zero, which is found on the first read; add, sub and eq do
// two reads through the single read port of the stack memory; mul and div also
// do two reads, then mul forms three partial products on a half-width multiplier
// and div one quotient bit per cycle. The next instruction is accepted once the
// previous one has been committed, so instructions never overlap.
// Reset clears depth, pointer, halt flag and program_length; stack contents
// are left as they are and are never read before being written.
// A result waiting on a stalled receiver sits in the output register; the next
// instruction is still accepted and processed, and waits at its write-back
// until the output register is taken.
module stack_machine_execute_unit_top #(
  parameter int unsigned STACK_DEPTH   = 1024,
  parameter int unsigned PROGRAM_DEPTH = 1024
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  sme_in_if.sink    inst_i,
  sme_out_if.source res_o,
  sme_cfg_if.sink   cfg_i
);
  import sme_pkg::*;

  localparam int unsigned AW = $clog2(STACK_DEPTH);
  localparam int unsigned DW = $clog2(STACK_DEPTH + 1);

  state_e            state_q, state_d;
  op_e               op_q, op_d;
  word_t             operand_q, operand_d;
  status_e           status_q, status_d;
  word_t             b_q, b_d;
  word_t             res_q, res_d;
  logic [DW-1:0]     depth_q, depth_d;
  word_t             ptr_q, ptr_d;
  logic              halt_q, halt_d;
  logic [PLEN_W-1:0] plen_q;

  logic                   out_valid_q;
  status_e                out_status_q;
  word_t                  out_ptr_q;
  logic                   out_halt_q;
  logic                   out_emv_q;
  word_t                  out_emval_q;
  logic [DEPTH_OUT_W-1:0] out_depth_q;
  logic                   out_load, out_emv_d;
  word_t                  out_emval_d;
  logic                   out_free;

  word_t         mem_q [STACK_DEPTH];
  word_t         rd_data_q;
  logic [AW-1:0] rd_addr, wr_addr;
  logic          wr_en;
  word_t         wr_data;

  logic          accept;
  op_e           op_in;
  status_e       status_in;
  logic          needs_rd;
  logic          access_ok, full, is_err;
  word_t         limit, plen_ext, depth_ext;
  logic [AW-1:0] top_addr;

  logic  mul_start, mul_done, div_start, div_done;
  word_t mul_res, div_res;

  assign inst_i.ready = (state_q == S_IDLE);
  assign accept       = inst_i.valid && inst_i.ready;
  assign op_in        = op_e'(inst_i.opcode);
  assign out_free     = !out_valid_q || res_o.ready;
  assign is_err       = (status_q != ST_OK) && (status_q != ST_OK_NOP);
  assign cfg_i.ready  = 1'b1;

  // pointer legality and stack bounds
  always_comb begin
    plen_ext  = WORD_W'(plen_q);
    limit     = (plen_ext > WORD_W'(PROGRAM_DEPTH)) ? WORD_W'(PROGRAM_DEPTH) : plen_ext;
    access_ok = !ptr_q[WORD_W-1] && (ptr_q < limit);
    depth_ext = WORD_W'(depth_q);
    full      = (depth_q >= DW'(STACK_DEPTH));
    top_addr  = depth_q[AW-1:0] - AW'(1);
  end

  // checks done on the incoming instruction
  always_comb begin
    status_in = ST_OK;
    needs_rd  = 1'b0;
    if (!access_ok) begin
      status_in = ST_ILLEGAL_ACCESS;
    end else begin
      case (op_in)
        OP_NOP: status_in = ST_OK_NOP;
        OP_PUSH: begin
          if (full) status_in = ST_OVERFLOW;
        end
        OP_DUP: begin
          needs_rd = 1'b1;
          if (full) begin
            status_in = ST_OVERFLOW;
          end else if (!inst_i.operand[WORD_W-1] && (inst_i.operand >= depth_ext)) begin
            status_in = ST_UNDERFLOW;
          end else if (inst_i.operand[WORD_W-1]) begin
            status_in = ST_ILLEGAL_OPERAND;
          end
        end
        OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_EQ: begin
          needs_rd = 1'b1;
          if (depth_q < DW'(2)) status_in = ST_UNDERFLOW;
        end
        OP_JMP_IF, OP_EMIT: begin
          needs_rd = 1'b1;
          if (depth_q == '0) status_in = ST_UNDERFLOW;
        end
        OP_JMP, OP_HALT: status_in = ST_OK;
        default: status_in = ST_ILLEGAL_OP;
      endcase
    end
  end

  // read address: first operand on accept, second one in the read state
  always_comb begin
    if (state_q == S_IDLE) begin
      if (op_in == OP_DUP) begin
        rd_addr = top_addr - inst_i.operand[AW-1:0];
      end else begin
        rd_addr = top_addr;
      end
    end else begin
      rd_addr = depth_q[AW-1:0] - AW'(2);
    end
  end

  // sequencer, commit and result formation
  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    operand_d   = operand_q;
    status_d    = status_q;
    b_d         = b_q;
    res_d       = res_q;
    depth_d     = depth_q;
    ptr_d       = ptr_q;
    halt_d      = halt_q;
    mul_start   = 1'b0;
    div_start   = 1'b0;
    wr_en       = 1'b0;
    wr_addr     = depth_q[AW-1:0];
    wr_data     = operand_q;
    out_load    = 1'b0;
    out_emv_d   = 1'b0;
    out_emval_d = '0;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          op_d      = op_in;
          operand_d = inst_i.operand;
          status_d  = status_in;
          if (status_in == ST_OK && needs_rd) begin
            state_d = S_RD;
          end else begin
            state_d = S_WB;
          end
        end
      end
      S_RD: begin
        b_d = rd_data_q;
        if (op_q == OP_DIV && rd_data_q == '0) begin
          status_d = ST_DIV_ZERO;
          state_d  = S_WB;
        end else if (op_q == OP_ADD || op_q == OP_SUB || op_q == OP_MUL ||
                     op_q == OP_DIV || op_q == OP_EQ) begin
          state_d = S_RD2;
        end else begin
          state_d = S_WB;
        end
      end
      S_RD2: begin
        case (op_q)
          OP_ADD: begin
            res_d   = rd_data_q + b_q;
            state_d = S_WB;
          end
          OP_SUB: begin
            res_d   = rd_data_q - b_q;
            state_d = S_WB;
          end
          OP_MUL: begin
            mul_start = 1'b1;
            state_d   = S_MUL;
          end
          OP_DIV: begin
            div_start = 1'b1;
            state_d   = S_DIV;
          end
          default: begin
            res_d   = (rd_data_q == b_q) ? WORD_W'(1) : '0;
            state_d = S_WB;
          end
        endcase
      end
      S_MUL: begin
        if (mul_done) begin
          res_d   = mul_res;
          state_d = S_WB;
        end
      end
      S_DIV: begin
        if (div_done) begin
          res_d   = div_res;
          state_d = S_WB;
        end
      end
      S_WB: begin
        if (out_free) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
          if (!is_err) begin
            case (op_q)
              OP_NOP: ptr_d = ptr_q + WORD_W'(1);
              OP_PUSH: begin
                wr_en   = 1'b1;
                depth_d = depth_q + DW'(1);
                ptr_d   = ptr_q + WORD_W'(1);
              end
              OP_DUP: begin
                wr_en   = 1'b1;
                wr_data = b_q;
                depth_d = depth_q + DW'(1);
                ptr_d   = ptr_q + WORD_W'(1);
              end
              OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_EQ: begin
                wr_en   = 1'b1;
                wr_addr = depth_q[AW-1:0] - AW'(2);
                wr_data = res_q;
                depth_d = depth_q - DW'(1);
                ptr_d   = ptr_q + WORD_W'(1);
              end
              OP_JMP: ptr_d = operand_q;
              OP_JMP_IF: begin
                if (b_q != '0) begin
                  depth_d = depth_q - DW'(1);
                  ptr_d   = operand_q;
                end else begin
                  ptr_d = ptr_q + WORD_W'(1);
                end
              end
              OP_HALT: halt_d = 1'b1;
              OP_EMIT: begin
                out_emv_d   = 1'b1;
                out_emval_d = b_q;
                depth_d     = depth_q - DW'(1);
                ptr_d       = ptr_q + WORD_W'(1);
              end
              default: ptr_d = ptr_q;
            endcase
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // control and architectural state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      depth_q     <= '0;
      ptr_q       <= '0;
      halt_q      <= 1'b0;
      plen_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      depth_q <= depth_d;
      ptr_q   <= ptr_d;
      halt_q  <= halt_d;
      if (cfg_i.valid && cfg_i.ready) begin
        plen_q <= cfg_i.program_length;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // instruction and result payload
  always_ff @(posedge clk_i) begin
    op_q      <= op_d;
    operand_q <= operand_d;
    status_q  <= status_d;
    b_q       <= b_d;
    res_q     <= res_d;
    if (out_load) begin
      out_status_q <= status_q;
      out_ptr_q    <= ptr_d;
      out_halt_q   <= halt_d;
      out_emv_q    <= out_emv_d;
      out_emval_q  <= out_emval_d;
      out_depth_q  <= DEPTH_OUT_W'(depth_d);
    end
  end

  // word stack memory, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_data_q <= mem_q[rd_addr];
  end

  sme_mul u_mul (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (mul_start),
    .a_i      (rd_data_q),
    .b_i      (b_q),
    .done_o   (mul_done),
    .result_o (mul_res)
  );

  sme_div u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (div_start),
    .a_i      (rd_data_q),
    .b_i      (b_q),
    .done_o   (div_done),
    .result_o (div_res)
  );

  assign res_o.valid        = out_valid_q;
  assign res_o.status       = out_status_q;
  assign res_o.next_pointer = out_ptr_q;
  assign res_o.halted       = out_halt_q;
  assign res_o.emit_valid   = out_emv_q;
  assign res_o.emit_value   = out_emval_q;
  assign res_o.stack_depth  = out_depth_q;

  // checks
  a_depth_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    WORD_W'(depth_q) <= WORD_W'(STACK_DEPTH))
    else $error("stack depth beyond capacity");

  a_err_no_change: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WB && out_free && is_err) |=>
      ($stable(depth_q) && $stable(ptr_q) && $stable(halt_q)))
    else $error("failed instruction changed state");

  a_emit_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_emv_q) |-> (out_status_q == ST_OK))
    else $error("emit flagged on a failed instruction");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q != S_IDLE))
    else $error("accepted instruction not taken up");

endmodule
